>>> sv/msp_pkg.sv
// Shared constants for the Prim spanning tree block.
// Used by the top level and the checker; no dependencies.
`default_nettype none
package msp_pkg;
    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int VERT_W           = 6;
    localparam int OP_W             = 2;
    localparam int CFG_ADDR_W       = 3;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 3'd0;
    localparam logic [VERT_W-1:0]     VERTEX_COUNT_RESET = 6'd2;
endpackage
`default_nettype wire

>>> sv/msp_cell.sv
// One cell of the vertex ring: holds one vertex record and passes it on.
// Depends on nothing; width is set by the top level.
`default_nettype none
module msp_cell #(
    parameter int W = 22
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);
    logic [W-1:0] rec_reg;

    // shift the record one place along the ring
    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= d;
        end
    end

    assign q = rec_reg;
endmodule
`default_nettype wire

>>> sv/msp_update.sv
// Update point of the vertex ring: relaxes one record against one matrix
// entry and tracks the least distance seen in the pass. No package needed.
`default_nettype none
module msp_update #(
    parameter int VW = 5,
    parameter int NW = 6,
    parameter int WB = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              clear_min,
    input  wire logic              en,
    input  wire logic              init,
    input  wire logic [VW-1:0]     col,
    input  wire logic [NW-1:0]     n,
    input  wire logic [VW-1:0]     pick_in,
    input  wire logic [WB-1:0]     row_w,
    input  wire logic [VW+WB:0]    rec_in,
    output logic      [VW+WB:0]    rec_out,
    output logic                   best_found,
    output logic      [VW-1:0]     best_pick,
    output logic      [VW-1:0]     best_near,
    output logic      [WB-1:0]     best_dist
);
    logic          in_tree_old, in_tree_new;
    logic [VW-1:0] near_old, near_new;
    logic [WB-1:0] dist_old, dist_new;
    logic          excluded;

    logic          found_reg, found_next;
    logic [VW-1:0] pick_reg, pick_next;
    logic [VW-1:0] near_reg, near_next;
    logic [WB-1:0] least_reg, least_next;

    assign {in_tree_old, near_old, dist_old} = rec_in;
    assign excluded = (col == '0) || (32'(col) >= 32'(n));

    // relax the record with the current row entry
    always_comb begin
        if (init) begin
            in_tree_new = excluded;
            near_new    = '0;
            dist_new    = row_w;
        end else begin
            in_tree_new = in_tree_old || (col == pick_in);
            near_new    = near_old;
            dist_new    = dist_old;
            if (!in_tree_new && (row_w < dist_old)) begin
                near_new = pick_in;
                dist_new = row_w;
            end
        end
    end

    assign rec_out = {in_tree_new, near_new, dist_new};

    // keep the first strictly smaller distance of the pass
    always_comb begin
        found_next = found_reg;
        pick_next  = pick_reg;
        near_next  = near_reg;
        least_next = least_reg;
        if (clear_min) begin
            found_next = 1'b0;
            least_next = '1;
        end else if (en && !in_tree_new && (dist_new < least_reg)) begin
            found_next = 1'b1;
            pick_next  = col;
            near_next  = near_new;
            least_next = dist_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            least_reg <= '1;
        end else begin
            found_reg <= found_next;
            least_reg <= least_next;
        end
        pick_reg <= pick_next;
        near_reg <= near_next;
    end

    assign best_found = found_reg;
    assign best_pick  = pick_reg;
    assign best_near  = near_reg;
    assign best_dist  = least_reg;
endmodule
`default_nettype wire

>>> sv/msp_matrix.sv
// Weight matrix storage: one write port, one registered read port.
// No package needed; depth and widths come from the top level.
`default_nettype none
module msp_matrix #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WB    = 16
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [WB-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [WB-1:0] rdata
);
    logic [WB-1:0] mem [DEPTH];
    logic [WB-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> sv/minimum_spanning_tree_prim_unit.sv
// Top level of the Prim spanning tree block: sequencer, matrix and ring.
// Depends on msp_pkg, msp_matrix, msp_cell and msp_update.
//
// Use: the s_ channel takes requests: load edge (op 0), run (op 1) and
// clear matrix (op 2). A load writes both symmetric entries. A clear
// sweeps all MAX_VERTICES^2 matrix entries, one entry a cycle. A run
// walks a ring of MAX_VERTICES vertex cells past one matrix row per
// round, read through the single matrix read port, and emits n-1
// results (or stops early with a disconnected result), the final one
// flagged last. The m_ channel holds each result in an output register;
// while the receiver stalls the next round waits.
// vertex_count is written over the APB-style port at byte address 0.
// After reset the block clears the matrix (all MAX_VERTICES^2 entries,
// 1024 at the default size) with s_ready low; configuration writes are
// taken.
`default_nettype none
module minimum_spanning_tree_prim_unit #(
    parameter int MAX_VERTICES = msp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = msp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [msp_pkg::OP_W-1:0]      s_op,
    input  wire logic [msp_pkg::VERT_W-1:0]    s_vert_a,
    input  wire logic [msp_pkg::VERT_W-1:0]    s_vert_b,
    input  wire logic [WEIGHT_BITS-1:0]        s_weight,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [msp_pkg::VERT_W-1:0]    m_tree_vertex,
    output logic      [msp_pkg::VERT_W-1:0]    m_parent_vertex,
    output logic      [WEIGHT_BITS-1:0]        m_edge_weight,
    output logic                               m_disconnected,
    output logic                               m_last
);
    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int REC_W = 1 + VW + WEIGHT_BITS;
    localparam int XW    = msp_pkg::VERT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD2 = 3'd2;
    localparam logic [2:0] ST_PASS  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0] addr2_reg, addr2_next;
    logic [WEIGHT_BITS-1:0] w2_reg, w2_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] round_reg, round_next;
    logic [VW-1:0] row_reg, row_next;
    logic          init_reg, init_next;
    logic [VW-1:0] col_reg, col_next;
    logic          issue_reg, issue_next;
    logic          rd_valid_reg;
    logic [VW-1:0] rd_col_reg;
    logic [XW-1:0] vc_reg;

    logic          m_valid_reg, m_valid_next;
    logic [XW-1:0] tv_reg, tv_next, pv_reg, pv_next;
    logic [WEIGHT_BITS-1:0] ew_reg, ew_next;
    logic          disc_reg, disc_next, last_reg, last_next;

    logic          s_fire, slot_free, pass_start, pass_done, is_last;
    logic          a_ok, b_ok;
    logic [AW-1:0] addr_ab, addr_ba;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [WEIGHT_BITS-1:0] wdata, rdata;

    logic [REC_W-1:0] chain [MAX_VERTICES];
    logic [REC_W-1:0] rec_new;
    logic          best_found;
    logic [VW-1:0] best_pick, best_near;
    logic [WEIGHT_BITS-1:0] best_dist;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= msp_pkg::VERTEX_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == msp_pkg::REG_VERTEX_COUNT)) begin
            vc_reg <= pwdata[XW-1:0];
        end
    end
    assign prdata = (paddr == msp_pkg::REG_VERTEX_COUNT) ? {{(32-XW){1'b0}}, vc_reg} : '0;

    // request decode
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign a_ok      = (s_vert_a != '0) && (32'(s_vert_a) <= MAX_VERTICES);
    assign b_ok      = (s_vert_b != '0) && (32'(s_vert_b) <= MAX_VERTICES);
    assign addr_ab   = AW'(AW'(s_vert_a - XW'(1)) * AW'(MAX_VERTICES)) + AW'(s_vert_b - XW'(1));
    assign addr_ba   = AW'(AW'(s_vert_b - XW'(1)) * AW'(MAX_VERTICES)) + AW'(s_vert_a - XW'(1));
    assign pass_done = rd_valid_reg && (rd_col_reg == VW'(MAX_VERTICES - 1));
    assign is_last   = ({1'b0, round_reg} + (NW+1)'(2)) == {1'b0, n_reg};

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr2_next   = addr2_reg;
        w2_next      = w2_reg;
        n_next       = n_reg;
        round_next   = round_reg;
        row_next     = row_reg;
        init_next    = init_reg;
        col_next     = col_reg;
        issue_next   = issue_reg;
        pass_start   = 1'b0;
        we           = 1'b0;
        waddr        = clr_cnt_reg;
        wdata        = '1;
        m_valid_next = m_valid_reg && !m_ready;
        tv_next      = tv_reg;
        pv_next      = pv_reg;
        ew_next      = ew_reg;
        disc_next    = disc_reg;
        last_next    = last_reg;

        // advance the read column while a pass issues
        if (issue_reg) begin
            col_next = col_reg + VW'(1);
            if (col_reg == VW'(MAX_VERTICES - 1)) begin
                issue_next = 1'b0;
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                we           = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_op == msp_pkg::OP_LOAD) begin
                        if (a_ok && b_ok) begin
                            we         = 1'b1;
                            waddr      = addr_ab;
                            wdata      = s_weight;
                            addr2_next = addr_ba;
                            w2_next    = s_weight;
                            state_next = ST_LOAD2;
                        end
                    end else if (s_op == msp_pkg::OP_RUN) begin
                        if (vc_reg < XW'(2)) begin
                            n_next = NW'(2);
                        end else if (32'(vc_reg) > MAX_VERTICES) begin
                            n_next = NW'(MAX_VERTICES);
                        end else begin
                            n_next = NW'(vc_reg);
                        end
                        round_next = '0;
                        row_next   = '0;
                        init_next  = 1'b1;
                        col_next   = '0;
                        issue_next = 1'b1;
                        pass_start = 1'b1;
                        state_next = ST_PASS;
                    end else if (s_op == msp_pkg::OP_CLEAR) begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                end
            end
            ST_LOAD2: begin
                we         = 1'b1;
                waddr      = addr2_reg;
                wdata      = w2_reg;
                state_next = ST_IDLE;
            end
            ST_PASS: begin
                if (pass_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (!best_found) begin
                        tv_next    = '0;
                        pv_next    = '0;
                        ew_next    = '1;
                        disc_next  = 1'b1;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        tv_next    = XW'(best_pick) + XW'(1);
                        pv_next    = XW'(best_near) + XW'(1);
                        ew_next    = best_dist;
                        disc_next  = 1'b0;
                        last_next  = is_last;
                        round_next = round_reg + NW'(1);
                        if (is_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            row_next   = best_pick;
                            init_next  = 1'b0;
                            col_next   = '0;
                            issue_next = 1'b1;
                            pass_start = 1'b1;
                            state_next = ST_PASS;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= issue_reg;
            m_valid_reg  <= m_valid_next;
        end
        addr2_reg  <= addr2_next;
        w2_reg     <= w2_next;
        n_reg      <= n_next;
        round_reg  <= round_next;
        row_reg    <= row_next;
        init_reg   <= init_next;
        col_reg    <= col_next;
        rd_col_reg <= col_reg;
        tv_reg     <= tv_next;
        pv_reg     <= pv_next;
        ew_reg     <= ew_next;
        disc_reg   <= disc_next;
        last_reg   <= last_next;
    end

    assign raddr = AW'(AW'(row_reg) * AW'(MAX_VERTICES)) + AW'(col_reg);

    msp_matrix #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .WB   (WEIGHT_BITS)
    ) u_matrix (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    msp_update #(
        .VW(VW),
        .NW(NW),
        .WB(WEIGHT_BITS)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear_min (pass_start),
        .en        (rd_valid_reg),
        .init      (init_reg),
        .col       (rd_col_reg),
        .n         (n_reg),
        .pick_in   (row_reg),
        .row_w     (rdata),
        .rec_in    (chain[MAX_VERTICES-1]),
        .rec_out   (rec_new),
        .best_found(best_found),
        .best_pick (best_pick),
        .best_near (best_near),
        .best_dist (best_dist)
    );

    // ring of vertex cells, rotating once per pass
    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_ring
        msp_cell #(.W(REC_W)) u_cell (
            .aclk(aclk),
            .en  (rd_valid_reg),
            .d   ((i == 0) ? rec_new : chain[(i == 0) ? 0 : i-1]),
            .q   (chain[i])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_tree_vertex   = tv_reg;
    assign m_parent_vertex = pv_reg;
    assign m_edge_weight   = ew_reg;
    assign m_disconnected  = disc_reg;
    assign m_last          = last_reg;
endmodule
`default_nettype wire

>>> sv/msp_checker.sv
// Port-level checks for the Prim spanning tree block, bound to the top.
// Depends on msp_pkg for field widths.
`default_nettype none
module msp_checker #(
    parameter int WB = msp_pkg::WEIGHT_BITS_DEF
) (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [msp_pkg::VERT_W-1:0] m_tree_vertex,
    input wire logic [msp_pkg::VERT_W-1:0] m_parent_vertex,
    input wire logic [WB-1:0]              m_edge_weight,
    input wire logic                       m_disconnected,
    input wire logic                       m_last
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tree_vertex) && $stable(m_edge_weight))
        else $error("result dropped or changed under stall");

    a_disc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_disconnected |-> m_last && (m_tree_vertex == '0) && (m_edge_weight == '1))
        else $error("disconnected result malformed");

    a_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_disconnected |-> (m_tree_vertex != '0) && (m_parent_vertex != '0))
        else $error("tree edge names vertex zero");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during matrix clear");
endmodule

bind minimum_spanning_tree_prim_unit msp_checker #(.WB(WEIGHT_BITS)) u_msp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_tree_vertex  (m_tree_vertex),
    .m_parent_vertex(m_parent_vertex),
    .m_edge_weight  (m_edge_weight),
    .m_disconnected (m_disconnected),
    .m_last         (m_last)
);
`default_nettype wire
